// ===== rtl/core/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

	localparam int DEPTH   = 16;
	localparam int COUNT_W = 5;
	localparam int DATA_W  = 32;

	typedef enum logic [1:0] {
		REQ_INSERT = 2'd0,
		REQ_REMOVE = 2'd1,
		REQ_CLEAR  = 2'd2
	} req_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		OP_HOLD,
		OP_INSERT,
		OP_REMOVE,
		OP_CLEAR
	} cell_op_t;

	typedef struct packed {
		cell_op_t                   op;
		logic                       mode;
		logic signed [DATA_W-1:0]   value;
	} cell_ctrl_t;

	typedef struct packed {
		logic [1:0]                 req_type;
		logic signed [DATA_W-1:0]   value;
	} in_word_t;

	typedef struct packed {
		logic signed [DATA_W-1:0]   head_value;
		logic                       head_valid;
		logic [COUNT_W-1:0]         entry_count;
		logic [1:0]                 status;
	} out_word_t;

endpackage

// ===== rtl/core/sorted_priority_queue_top.sv =====
// ----------------------------------------------------------------------------
// sorted_priority_queue_top
// Bounded sorted priority queue built as a chain of compare-and-shift cells.
// ----------------------------------------------------------------------------
// Result word strobed on done in the cycle after start is accepted.
// Throughput: one request word per cycle; every cell compares in parallel.
// busy stays low; results cannot be stalled by the receiver.
// Reset: count and all cell valid bits clear, queue_mode returns to 0.
module sorted_priority_queue_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  spq_pkg::in_word_t  cmd,
	output logic               done,
	output spq_pkg::out_word_t result,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_data
);
	import spq_pkg::*;

	logic                     mode_q;
	logic [COUNT_W-1:0]       count_q;
	logic                     done_q;
	status_t                  status_q;
	cell_ctrl_t               ctrl;
	status_t                  status_d;
	logic [COUNT_W-1:0]       count_d;
	logic                     accept;

	logic signed [DATA_W-1:0] cell_value [DEPTH];
	logic                     cell_valid [DEPTH];
	logic                     cell_placed [DEPTH];

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;

	always_comb begin
		ctrl.op    = OP_HOLD;
		ctrl.mode  = mode_q;
		ctrl.value = cmd.value;
		status_d   = ST_OK;
		count_d    = count_q;
		if (accept) begin
			unique case (cmd.req_type)
				REQ_INSERT: begin
					if (count_q == COUNT_W'(DEPTH)) begin
						status_d = ST_FULL;
					end else begin
						ctrl.op = OP_INSERT;
						count_d = count_q + 1'b1;
					end
				end
				REQ_REMOVE: begin
					if (count_q == '0) begin
						status_d = ST_EMPTY;
					end else begin
						ctrl.op = OP_REMOVE;
						count_d = count_q - 1'b1;
					end
				end
				REQ_CLEAR: begin
					ctrl.op = OP_CLEAR;
					count_d = '0;
				end
				default: ctrl.op = OP_HOLD;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= 1'b0;
			count_q  <= '0;
			done_q   <= 1'b0;
			status_q <= ST_OK;
		end else begin
			if (cfg_valid && cfg_ready) begin
				mode_q <= cfg_data;
			end
			count_q  <= count_d;
			done_q   <= accept;
			status_q <= status_d;
		end
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic signed [DATA_W-1:0] pv;
		logic                     pval;
		logic                     pplaced;
		logic signed [DATA_W-1:0] nv;
		logic                     nval;

		if (i == 0) begin : g_head
			assign pv      = cell_value[0];
			assign pval    = 1'b1;
			assign pplaced = 1'b0;
		end else begin : g_body
			assign pv      = cell_value[i-1];
			assign pval    = cell_valid[i-1];
			assign pplaced = cell_placed[i-1];
		end

		if (i == DEPTH-1) begin : g_tail
			assign nv   = cell_value[i];
			assign nval = 1'b0;
		end else begin : g_mid
			assign nv   = cell_value[i+1];
			assign nval = cell_valid[i+1];
		end

		spq_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.prev_value (pv),
			.prev_valid (pval),
			.prev_placed(pplaced),
			.next_value (nv),
			.next_valid (nval),
			.value      (cell_value[i]),
			.valid      (cell_valid[i]),
			.placed     (cell_placed[i])
		);
	end

	assign done               = done_q;
	assign result.head_value  = cell_valid[0] ? cell_value[0] : '0;
	assign result.head_valid  = cell_valid[0];
	assign result.entry_count = count_q;
	assign result.status      = status_q;

	a_done_follows_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> done)
		else $error("done missing after accepted word");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_W'(DEPTH))
		else $error("entry count above depth");

	a_head_matches_count: assert property (@(posedge clk) disable iff (!arst_n)
		cell_valid[0] == (count_q != '0))
		else $error("head valid bit disagrees with count");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status_q == ST_FULL) |-> (count_q == COUNT_W'(DEPTH)))
		else $error("full status with free slots");

	a_tail_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cell_valid[DEPTH-1] == (count_q == COUNT_W'(DEPTH)))
		else $error("tail valid bit disagrees with count");

endmodule

// ===== rtl/core/spq_cell.sv =====
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: holds a value and a valid bit, shifts toward
// the tail on insert and toward the head on remove.
// ----------------------------------------------------------------------------
module spq_cell (
	input  logic                              clk,
	input  logic                              arst_n,
	input  spq_pkg::cell_ctrl_t               ctrl,
	input  logic signed [spq_pkg::DATA_W-1:0] prev_value,
	input  logic                              prev_valid,
	input  logic                              prev_placed,
	input  logic signed [spq_pkg::DATA_W-1:0] next_value,
	input  logic                              next_valid,
	output logic signed [spq_pkg::DATA_W-1:0] value,
	output logic                              valid,
	output logic                              placed
);
	import spq_pkg::*;

	logic signed [DATA_W-1:0] value_q;
	logic                     valid_q;
	logic                     hit;

	// insert position: first slot that is empty or fails the ordering test
	always_comb begin
		if (ctrl.mode) begin
			hit = !valid_q || (value_q < ctrl.value);
		end else begin
			hit = !valid_q || (value_q >= ctrl.value);
		end
	end

	assign placed = prev_placed || hit;
	assign value  = value_q;
	assign valid  = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			unique case (ctrl.op)
				OP_INSERT: valid_q <= valid_q || prev_valid;
				OP_REMOVE: valid_q <= next_valid;
				OP_CLEAR:  valid_q <= 1'b0;
				default:   valid_q <= valid_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (ctrl.op)
			OP_INSERT: begin
				if (prev_placed) begin
					value_q <= prev_value;
				end else if (hit) begin
					value_q <= ctrl.value;
				end
			end
			OP_REMOVE: value_q <= next_value;
			default:   value_q <= value_q;
		endcase
	end

endmodule

// ===== verif/tb_sorted_priority_queue_top.sv =====
// ----------------------------------------------------------------------------
// tb_sorted_priority_queue_top
// Drives insert, remove, clear and unused request words into the sorted
// priority queue, predicts the head, count and status of every result word
// from a software copy of the sorted list, and compares them field by field.
// A short directed table covers empty, full, extreme values and a mode switch
// with entries stored; randomized phases follow under both queue modes.
// ----------------------------------------------------------------------------
module tb_sorted_priority_queue_top;

	import spq_pkg::*;

	localparam logic [1:0] REQ_NOP   = 2'd3;
	localparam int         LIMIT     = 200000;
	localparam int         N_PHASES  = 6;
	localparam int         PHASE_LEN = 150;
	localparam int         N_DIR     = 28;

	typedef enum logic { ROW_REQ, ROW_CFG } row_kind_t;

	typedef struct packed {
		row_kind_t   kind;
		logic [1:0]  req;
		logic [31:0] val;
		logic        pinned;
		out_word_t   want;
	} dir_row_t;

	localparam out_word_t W_EMPTY_OK = '{32'sd0, 1'b0, 5'd0, ST_OK};
	localparam out_word_t NO_WANT    = '0;

	localparam dir_row_t DIR_TAB [N_DIR] = '{
		'{ROW_REQ, REQ_REMOVE, 32'h0000_0000, 1'b1, '{32'sd0, 1'b0, 5'd0, ST_EMPTY}},
		'{ROW_REQ, REQ_CLEAR,  32'h0000_0000, 1'b1, W_EMPTY_OK},
		'{ROW_REQ, REQ_NOP,    32'hFFFF_FFFF, 1'b1, W_EMPTY_OK},
		'{ROW_REQ, REQ_INSERT, 32'h7FFF_FFFF, 1'b1, '{32'h7FFF_FFFF, 1'b1, 5'd1, ST_OK}},
		'{ROW_REQ, REQ_INSERT, 32'h8000_0000, 1'b1, '{32'h8000_0000, 1'b1, 5'd2, ST_OK}},
		'{ROW_REQ, REQ_INSERT, 32'h0000_0000, 1'b0, NO_WANT},
		'{ROW_REQ, REQ_INSERT, 32'hFFFF_FFFF, 1'b0, NO_WANT},
		'{ROW_REQ, REQ_INSERT, 32'h0000_0001, 1'b0, NO_WANT},
		'{ROW_REQ, REQ_INSERT, 32'h0000_0005, 1'b0, NO_WANT},
		'{ROW_REQ, REQ_INSERT, 32'h0000_0005, 1'b0, NO_WANT},
		'{ROW_REQ, REQ_INSERT, 32'h5555_5555, 1'b0, NO_WANT},
		'{ROW_REQ, REQ_INSERT, 32'hAAAA_AAAA, 1'b0, NO_WANT},
		'{ROW_REQ, REQ_INSERT, 32'h8000_0000, 1'b0, NO_WANT},
		'{ROW_REQ, REQ_INSERT, 32'h7FFF_FFFF, 1'b0, NO_WANT},
		'{ROW_REQ, REQ_INSERT, 32'hFFFF_FF9C, 1'b0, NO_WANT},
		'{ROW_REQ, REQ_INSERT, 32'h0000_0064, 1'b0, NO_WANT},
		'{ROW_REQ, REQ_INSERT, 32'h0000_FFFF, 1'b0, NO_WANT},
		'{ROW_REQ, REQ_INSERT, 32'hFFFF_0000, 1'b0, NO_WANT},
		'{ROW_REQ, REQ_INSERT, 32'h0000_002A, 1'b0, NO_WANT},
		'{ROW_REQ, REQ_INSERT, 32'h0000_0007, 1'b1, '{32'h8000_0000, 1'b1, 5'd16, ST_FULL}},
		'{ROW_CFG, REQ_INSERT, 32'h0000_0001, 1'b0, NO_WANT},
		'{ROW_REQ, REQ_REMOVE, 32'h1234_5678, 1'b0, NO_WANT},
		'{ROW_REQ, REQ_INSERT, 32'h0000_0003, 1'b0, NO_WANT},
		'{ROW_REQ, REQ_INSERT, 32'h8000_0000, 1'b0, NO_WANT},
		'{ROW_REQ, REQ_CLEAR,  32'hDEAD_BEEF, 1'b1, W_EMPTY_OK},
		'{ROW_REQ, REQ_INSERT, 32'h0000_0009, 1'b1, '{32'sd9, 1'b1, 5'd1, ST_OK}},
		'{ROW_REQ, REQ_REMOVE, 32'h0000_0000, 1'b1, W_EMPTY_OK},
		'{ROW_CFG, REQ_INSERT, 32'h0000_0000, 1'b0, NO_WANT}
	};

	logic       clk;
	logic       arst_n;
	logic       start;
	logic       busy;
	in_word_t   cmd;
	logic       done;
	out_word_t  result;
	logic       cfg_valid;
	logic       cfg_ready;
	logic       cfg_data;

	logic       pin_on;
	out_word_t  pin_word;

	// software copy of the sorted list
	logic signed [31:0] q_vals [DEPTH];
	int                 q_cnt  = 0;
	logic               q_mode = 1'b0;

	out_word_t expected_words [$];
	int        accepted_n = 0;
	int        checked_n  = 0;
	int        cfg_n      = 0;
	int        err_n      = 0;
	int        full_n     = 0;
	int        empty_n    = 0;
	int        cyc        = 0;

	sorted_priority_queue_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic out_word_t queue_step(input in_word_t w);
		out_word_t          r;
		logic signed [31:0] v;
		int                 pos;
		int                 i;
		v = w.value;
		r = '0;
		r.status = ST_OK;
		case (w.req_type)
			REQ_INSERT: begin
				if (q_cnt >= DEPTH) begin
					r.status = ST_FULL;
				end else begin
					pos = 0;
					while (pos < q_cnt) begin
						if (q_mode == 1'b0 && q_vals[pos] >= v) break;
						if (q_mode == 1'b1 && q_vals[pos] < v) break;
						pos++;
					end
					for (i = q_cnt; i > pos; i--) q_vals[i] = q_vals[i-1];
					q_vals[pos] = v;
					q_cnt++;
				end
			end
			REQ_REMOVE: begin
				if (q_cnt == 0) begin
					r.status = ST_EMPTY;
				end else begin
					for (i = 0; i + 1 < q_cnt; i++) q_vals[i] = q_vals[i+1];
					q_cnt--;
				end
			end
			REQ_CLEAR: q_cnt = 0;
			default: ;
		endcase
		if (q_cnt > 0) begin
			r.head_value = q_vals[0];
			r.head_valid = 1'b1;
		end
		r.entry_count = q_cnt[COUNT_W-1:0];
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("MISMATCH word %0d %s: got %0h want %0h", checked_n, what, got, want);
		err_n++;
	endtask

	always @(posedge clk) begin
		out_word_t w;
		out_word_t p;
		cyc++;
		if (cyc > LIMIT) begin
			$display("timeout after %0d cycles", cyc);
			$display("tb_sorted_priority_queue_top failed");
			$finish;
		end else if (arst_n) begin
			if (done) begin
				if (expected_words.size() == 0) begin
					report_mismatch("unexpected word", result.head_value, '0);
				end else begin
					w = expected_words.pop_front();
					if (result.head_value !== w.head_value)
						report_mismatch("head_value", result.head_value, w.head_value);
					if (result.head_valid !== w.head_valid)
						report_mismatch("head_valid", 32'(result.head_valid),
							32'(w.head_valid));
					if (result.entry_count !== w.entry_count)
						report_mismatch("entry_count", 32'(result.entry_count),
							32'(w.entry_count));
					if (result.status !== w.status)
						report_mismatch("status", 32'(result.status), 32'(w.status));
				end
				checked_n++;
			end
			if (cfg_valid && cfg_ready) begin
				q_mode = cfg_data;
				cfg_n++;
			end
			if (start && !busy) begin
				p = queue_step(cmd);
				if (p.status == ST_FULL) full_n++;
				if (p.status == ST_EMPTY) empty_n++;
				expected_words.push_back(pin_on ? pin_word : p);
				accepted_n++;
			end
		end
	end

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_word(input in_word_t w, input logic pinned, input out_word_t want);
		int target;
		target = accepted_n + 1;
		start    <= 1'b1;
		cmd      <= w;
		pin_on   <= pinned;
		pin_word <= want;
		do @(negedge clk); while (accepted_n < target);
	endtask

	task automatic idle_for(input int n);
		if (n > 0) begin
			start <= 1'b0;
			cmd   <= in_word_t'(34'({$urandom, $urandom}));
			repeat (n) @(negedge clk);
		end
	endtask

	task automatic write_mode(input logic m);
		int target;
		start <= 1'b0;
		do @(negedge clk); while (expected_words.size() != 0);
		target    = cfg_n + 1;
		cfg_valid <= 1'b1;
		cfg_data  <= m;
		do @(negedge clk); while (cfg_n < target);
		cfg_valid <= 1'b0;
		cfg_data  <= 1'($urandom);
	endtask

	function automatic int pick_gap(input logic no_idle);
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 9))
			0:       return 32'h8000_0000;
			1:       return 32'h7FFF_FFFF;
			2:       return $urandom_range(0, 1) ? 32'h0 : 32'hFFFF_FFFF;
			3, 4, 5: return $urandom_range(0, 16) - 32'd8;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [1:0] pick_req(input int insert_pct);
		int r;
		r = $urandom_range(0, 99);
		if (r < 2) return REQ_CLEAR;
		if (r < 4) return REQ_NOP;
		if (r < 4 + insert_pct) return REQ_INSERT;
		return REQ_REMOVE;
	endfunction

	initial begin
		in_word_t w;
		logic     no_idle;
		int       insert_pct;
		int       p;
		int       k;
		start     = 1'b0;
		cmd       = '0;
		cfg_valid = 1'b0;
		cfg_data  = 1'b0;
		pin_on    = 1'b0;
		pin_word  = '0;
		arst_n    = 1'b0;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (k = 0; k < N_DIR; k++) begin
			if (DIR_TAB[k].kind == ROW_CFG) begin
				write_mode(DIR_TAB[k].val[0]);
			end else begin
				w = '{req_type: DIR_TAB[k].req, value: DIR_TAB[k].val};
				send_word(w, DIR_TAB[k].pinned, DIR_TAB[k].want);
				idle_for(pick_gap(1'b0));
			end
		end

		for (p = 0; p < N_PHASES; p++) begin
			write_mode(p < 2 ? logic'(p == 0) : logic'($urandom_range(0, 1)));
			if ($urandom_range(0, 1)) begin
				w = '{req_type: REQ_CLEAR, value: $urandom};
				send_word(w, 1'b0, NO_WANT);
			end
			no_idle = ($urandom_range(0, 3) == 0);
			insert_pct = 48;
			for (k = 0; k < PHASE_LEN; k++) begin
				if (k % 40 == 0) begin
					case ($urandom_range(0, 2))
						0:       insert_pct = 72;
						1:       insert_pct = 48;
						default: insert_pct = 28;
					endcase
				end
				w = '{req_type: pick_req(insert_pct), value: pick_value()};
				send_word(w, 1'b0, NO_WANT);
				idle_for(pick_gap(no_idle));
			end
		end

		start <= 1'b0;
		do @(negedge clk); while (expected_words.size() != 0);
		repeat (4) @(negedge clk);
		if (expected_words.size() != 0)
			report_mismatch("words never returned", expected_words.size(), 0);
		$display("%0d request words sent, %0d result words checked, %0d mode writes",
			accepted_n, checked_n, cfg_n);
		$display("%0d inserts refused on a full queue, %0d removes on an empty queue",
			full_n, empty_n);
		if (err_n == 0) begin
			$display("tb_sorted_priority_queue_top passed");
		end else begin
			$display("tb_sorted_priority_queue_top failed");
		end
		$finish;
	end

endmodule
